// ----- rtl/skf_pkg.sv -----
// Shared types, widths and codes for the scalar keyframe interpolator.
// No dependencies; every other file in rtl/ imports this package.
package skf_pkg;

    // Default number of fraction bits of t and of the values
    localparam int FRAC_BITS_DEF = 16;

    localparam int TIME_W     = 32;
    localparam int VAL_W      = 32;
    localparam int MODE_W     = 2;
    localparam int IN_DATA_W  = 3 * TIME_W + 4 * VAL_W;
    localparam int OUT_DATA_W = VAL_W;

    // Interpolation modes
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HERMITE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BEZIER  = 2'd3;

    // Saturation limits of the result
    localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

    // Key values and tangents carried down the pipe
    typedef struct packed {
        logic signed [VAL_W-1:0] left_value;
        logic signed [VAL_W-1:0] left_out_tangent;
        logic signed [VAL_W-1:0] right_in_tangent;
        logic signed [VAL_W-1:0] right_value;
    } vals_t;

    // Per-request control travelling with the data
    typedef struct packed {
        logic              bypass;   // equal key times or hold mode
        logic              t_zero;   // query at or before the span
        logic              t_one;    // query at or past the span end
        logic [MODE_W-1:0] mode;
    } tag_t;

endpackage

// ----- rtl/skf_pos.sv -----
// Position unit: key/query differences, span checks and a pipelined
// restoring divider giving one quotient bit per stage. Uses skf_pkg.
module skf_pos #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [skf_pkg::TIME_W-1:0]   query_time,
    input  logic [skf_pkg::TIME_W-1:0]   left_time,
    input  logic [skf_pkg::TIME_W-1:0]   right_time,
    input  skf_pkg::vals_t               in_vals,
    input  logic [skf_pkg::MODE_W-1:0]   in_mode,
    output logic                         out_valid,
    output logic [FRAC_BITS-1:0]         quot,
    output skf_pkg::tag_t                out_tag,
    output skf_pkg::vals_t               out_vals
);
    import skf_pkg::*;

    // Stage 1: signed 33-bit differences
    logic                valid1_reg;
    logic signed [32:0]  dq_reg, dk_reg;
    logic signed [32:0]  dq_next, dk_next;
    tag_t                tag1_reg, tag1_next;
    vals_t               vals1_reg;

    assign dq_next = {1'b0, query_time} - {1'b0, left_time};
    assign dk_next = {1'b0, right_time} - {1'b0, left_time};

    always_comb
    begin
        tag1_next        = '0;
        tag1_next.bypass = (left_time == right_time) || (in_mode == MODE_HOLD);
        tag1_next.mode   = in_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid1_reg <= 1'b0;
        else if (en)
            valid1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dq_reg    <= dq_next;
            dk_reg    <= dk_next;
            tag1_reg  <= tag1_next;
            vals1_reg <= in_vals;
        end
    end

    // Stage 2: magnitudes and the before-span check
    logic               valid2_reg;
    logic [TIME_W-1:0]  aq_reg, ak_reg;
    logic [32:0]        aq_full, ak_full;
    tag_t               tag2_reg, tag2_next;
    vals_t              vals2_reg;

    assign aq_full = dq_reg[32] ? (33'd0 - dq_reg) : dq_reg;
    assign ak_full = dk_reg[32] ? (33'd0 - dk_reg) : dk_reg;

    always_comb
    begin
        tag2_next        = tag1_reg;
        tag2_next.t_zero = (dq_reg == 33'd0) || (dq_reg[32] != dk_reg[32]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid2_reg <= 1'b0;
        else if (en)
            valid2_reg <= valid1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aq_reg    <= aq_full[TIME_W-1:0];
            ak_reg    <= ak_full[TIME_W-1:0];
            tag2_reg  <= tag2_next;
            vals2_reg <= vals1_reg;
        end
    end

    // Divider pipe; index 0 is the setup stage, index FRAC_BITS the last bit
    logic                 dv_valid_reg [0:FRAC_BITS];
    logic [TIME_W-1:0]    rem_reg      [0:FRAC_BITS];
    logic [TIME_W-1:0]    div_reg      [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] quo_reg      [0:FRAC_BITS];
    tag_t                 dv_tag_reg   [0:FRAC_BITS];
    vals_t                dv_vals_reg  [0:FRAC_BITS];

    // Stage 3: past-span check; saturated cases start with a zero remainder
    tag_t tag3_next;

    always_comb
    begin
        tag3_next       = tag2_reg;
        tag3_next.t_one = !tag2_reg.t_zero && (aq_reg >= ak_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (en)
            dv_valid_reg[0] <= valid2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]     <= (tag3_next.t_zero || tag3_next.t_one) ? '0 : aq_reg;
            div_reg[0]     <= ak_reg;
            quo_reg[0]     <= '0;
            dv_tag_reg[0]  <= tag3_next;
            dv_vals_reg[0] <= vals2_reg;
        end
    end

    // One quotient bit per stage
    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_div
        logic [33:0] trial;
        logic        fits;

        assign trial = {1'b0, rem_reg[i], 1'b0} - {2'b00, div_reg[i]};
        assign fits  = !trial[33];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[i+1] <= 1'b0;
            else if (en)
                dv_valid_reg[i+1] <= dv_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]     <= fits ? trial[TIME_W-1:0] : {rem_reg[i][TIME_W-2:0], 1'b0};
                div_reg[i+1]     <= div_reg[i];
                quo_reg[i+1]     <= {quo_reg[i][FRAC_BITS-2:0], fits};
                dv_tag_reg[i+1]  <= dv_tag_reg[i];
                dv_vals_reg[i+1] <= dv_vals_reg[i];
            end
        end
    end

    assign out_valid = dv_valid_reg[FRAC_BITS];
    assign quot      = quo_reg[FRAC_BITS];
    assign out_tag   = dv_tag_reg[FRAC_BITS];
    assign out_vals  = dv_vals_reg[FRAC_BITS];

endmodule

// ----- rtl/skf_wgt.sv -----
// Weight unit: powers of t and s with rounding, then the four per-mode
// basis weights in signed fixed point. Uses skf_pkg.
module skf_wgt #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [FRAC_BITS-1:0]        quot,
    input  skf_pkg::tag_t               in_tag,
    input  skf_pkg::vals_t              in_vals,
    output logic                        out_valid,
    output logic signed [FRAC_BITS+3:0] w0,
    output logic signed [FRAC_BITS+3:0] w1,
    output logic signed [FRAC_BITS+3:0] w2,
    output logic signed [FRAC_BITS+3:0] w3,
    output skf_pkg::vals_t              out_vals
);
    import skf_pkg::*;

    localparam int T_W  = FRAC_BITS + 1;
    localparam int W_W  = FRAC_BITS + 4;
    localparam int PP_W = 2 * T_W;
    localparam int Q_W  = 2 * T_W + 2;

    localparam logic [T_W-1:0]  ONE_T   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PP_W-1:0] HALF_PP = {{(PP_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [Q_W-1:0]  HALF_Q  = {{(Q_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [W_W-1:0] ONE_W = {3'b000, ONE_T};

    function automatic logic signed [W_W-1:0] to_w(input logic [T_W-1:0] x);
        return $signed({{(W_W-T_W){1'b0}}, x});
    endfunction

    // Stage A: t with span saturation, s = 1 - t
    logic            va_reg;
    logic [T_W-1:0]  ta_reg, sa_reg, ta_next;
    tag_t            taga_reg;
    vals_t           valsa_reg;

    assign ta_next = in_tag.t_one  ? ONE_T :
                     in_tag.t_zero ? '0    : {1'b0, quot};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg    <= ta_next;
            sa_reg    <= ONE_T - ta_next;
            taga_reg  <= in_tag;
            valsa_reg <= in_vals;
        end
    end

    // Stage B: squares
    logic            vb_reg;
    logic [T_W-1:0]  tb_reg, sb_reg, t2b_reg, s2b_reg;
    logic [PP_W-1:0] ptt, pss, rtt, rss;
    tag_t            tagb_reg;
    vals_t           valsb_reg;

    assign ptt = PP_W'(ta_reg) * PP_W'(ta_reg);
    assign pss = PP_W'(sa_reg) * PP_W'(sa_reg);
    assign rtt = ptt + HALF_PP;
    assign rss = pss + HALF_PP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tb_reg    <= ta_reg;
            sb_reg    <= sa_reg;
            t2b_reg   <= rtt[FRAC_BITS +: T_W];
            s2b_reg   <= rss[FRAC_BITS +: T_W];
            tagb_reg  <= taga_reg;
            valsb_reg <= valsa_reg;
        end
    end

    // Stage C: cubes and the two Bezier cross terms
    logic            vc_reg;
    logic [T_W-1:0]  tc_reg, sc_reg, t2c_reg, t3c_reg, s3c_reg, b1c_reg, b2c_reg;
    logic [T_W+1:0]  t_x3, t2_x3;
    logic [PP_W-1:0] pt3, ps3, rt3, rs3;
    logic [Q_W-1:0]  pb1, pb2, rb1, rb2;
    tag_t            tagc_reg;
    vals_t           valsc_reg;

    assign t_x3  = {2'b00, tb_reg} + {1'b0, tb_reg, 1'b0};
    assign t2_x3 = {2'b00, t2b_reg} + {1'b0, t2b_reg, 1'b0};
    assign pt3   = PP_W'(t2b_reg) * PP_W'(tb_reg);
    assign ps3   = PP_W'(s2b_reg) * PP_W'(sb_reg);
    assign pb1   = Q_W'(t_x3) * Q_W'(s2b_reg);
    assign pb2   = Q_W'(t2_x3) * Q_W'(sb_reg);
    assign rt3   = pt3 + HALF_PP;
    assign rs3   = ps3 + HALF_PP;
    assign rb1   = pb1 + HALF_Q;
    assign rb2   = pb2 + HALF_Q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (en)
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tc_reg    <= tb_reg;
            sc_reg    <= sb_reg;
            t2c_reg   <= t2b_reg;
            t3c_reg   <= rt3[FRAC_BITS +: T_W];
            s3c_reg   <= rs3[FRAC_BITS +: T_W];
            b1c_reg   <= rb1[FRAC_BITS +: T_W];
            b2c_reg   <= rb2[FRAC_BITS +: T_W];
            tagc_reg  <= tagb_reg;
            valsc_reg <= valsb_reg;
        end
    end

    // Stage D: basis weights per mode; bypass puts full weight on left_value
    logic                  vd_reg;
    logic signed [W_W-1:0] w0_reg, w1_reg, w2_reg, w3_reg;
    logic signed [W_W-1:0] w0_next, w1_next, w2_next, w3_next;
    logic signed [W_W-1:0] tw, t2w, t3w;
    vals_t                 valsd_reg;

    assign tw  = to_w(tc_reg);
    assign t2w = to_w(t2c_reg);
    assign t3w = to_w(t3c_reg);

    always_comb
    begin
        w0_next = ONE_W;
        w1_next = '0;
        w2_next = '0;
        w3_next = '0;
        if (!tagc_reg.bypass)
        begin
            case (tagc_reg.mode)
                MODE_LINEAR:
                begin
                    w0_next = to_w(sc_reg);
                    w3_next = tw;
                end
                MODE_HERMITE:
                begin
                    w0_next = ONE_W - (t2w + t2w + t2w) + (t3w + t3w);
                    w1_next = t3w - (t2w + t2w) + tw;
                    w2_next = t3w - t2w;
                    w3_next = (t2w + t2w + t2w) - (t3w + t3w);
                end
                MODE_BEZIER:
                begin
                    w0_next = to_w(s3c_reg);
                    w1_next = to_w(b1c_reg);
                    w2_next = to_w(b2c_reg);
                    w3_next = t3w;
                end
                default:
                begin
                    w0_next = ONE_W;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (en)
            vd_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w0_reg    <= w0_next;
            w1_reg    <= w1_next;
            w2_reg    <= w2_next;
            w3_reg    <= w3_next;
            valsd_reg <= valsc_reg;
        end
    end

    assign out_valid = vd_reg;
    assign w0        = w0_reg;
    assign w1        = w1_reg;
    assign w2        = w2_reg;
    assign w3        = w3_reg;
    assign out_vals  = valsd_reg;

endmodule

// ----- rtl/skf_mac.sv -----
// Weighted-sum unit: four products, a two-level adder tree, then rounding
// and saturation into the output register. Uses skf_pkg.
module skf_mac #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [FRAC_BITS+3:0] w0,
    input  logic signed [FRAC_BITS+3:0] w1,
    input  logic signed [FRAC_BITS+3:0] w2,
    input  logic signed [FRAC_BITS+3:0] w3,
    input  skf_pkg::vals_t              in_vals,
    output logic                        out_valid,
    output logic [skf_pkg::VAL_W-1:0]   out_value
);
    import skf_pkg::*;

    localparam int W_W   = FRAC_BITS + 4;
    localparam int P_W   = VAL_W + W_W;
    localparam int ACC_W = P_W + 2;
    localparam int R_W   = ACC_W + 1;
    localparam int Q_W   = R_W - FRAC_BITS;

    localparam logic signed [R_W-1:0] HALF_R =
        {{(R_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    // Stage 1: products
    logic                  v1_reg;
    logic signed [P_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [P_W-1:0] p0_next, p1_next, p2_next, p3_next;

    assign p0_next = $signed(in_vals.left_value)       * w0;
    assign p1_next = $signed(in_vals.left_out_tangent) * w1;
    assign p2_next = $signed(in_vals.right_in_tangent) * w2;
    assign p3_next = $signed(in_vals.right_value)      * w3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
    end

    // Stage 2: pair sums
    logic                v2_reg;
    logic signed [P_W:0] s01_reg, s23_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s01_reg <= {p0_reg[P_W-1], p0_reg} + {p1_reg[P_W-1], p1_reg};
            s23_reg <= {p2_reg[P_W-1], p2_reg} + {p3_reg[P_W-1], p3_reg};
        end
    end

    // Stage 3: full sum
    logic                    v3_reg;
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            acc_reg <= {s01_reg[P_W], s01_reg} + {s23_reg[P_W], s23_reg};
    end

    // Stage 4: round half up, floor shift, saturate
    logic                  v4_reg;
    logic [VAL_W-1:0]      value_reg, value_next;
    logic signed [R_W-1:0] rnd;
    logic signed [R_W-1:0] shifted;
    logic [Q_W-1:0]        q;
    logic                  in_range;

    assign rnd      = {acc_reg[ACC_W-1], acc_reg} + HALF_R;
    assign shifted  = rnd >>> FRAC_BITS;
    assign q        = shifted[Q_W-1:0];
    assign in_range = (q[Q_W-1:VAL_W-1] == '0) || (q[Q_W-1:VAL_W-1] == '1);

    always_comb
    begin
        if (in_range)
            value_next = q[VAL_W-1:0];
        else if (q[Q_W-1])
            value_next = SAT_MIN;
        else
            value_next = SAT_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            value_reg <= value_next;
    end

    assign out_valid = v4_reg;
    assign out_value = value_reg;

endmodule

// ----- rtl/scalar_keyframe_interpolator.sv -----
// Scalar keyframe interpolator: linear, hold, cubic Hermite and cubic Bezier.
// Top level; instantiates skf_pos, skf_wgt and skf_mac, uses skf_pkg.
//
// Usage:
//   One request on the s_ side carries a query time, two key times, the two
//   key values with their tangents (tdata) and the mode (tuser). One result,
//   the interpolated Q16.16 value saturated to 32 bits, leaves on the m_ side.
//   The divider that forms t takes one stage per fraction bit and is the
//   longest part of the pipe.
//   Throughput is one request per cycle while the receiver does not stall;
//   every stage carries a valid bit.
//   When the receiver stalls (m_tvalid high, m_tready low) the whole pipe
//   freezes and s_tready drops in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits: the block comes out empty and ready.
module scalar_keyframe_interpolator #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // query_time, left_time, right_time, left_value, left_out_tangent,
    // right_in_tangent, right_value (32 bits each, lowest bits first)
    input  logic [skf_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode
    input  logic [skf_pkg::MODE_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // value
    output logic [skf_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import skf_pkg::*;

    localparam int W_W = FRAC_BITS + 4;

    logic                  en;
    vals_t                 in_vals;
    logic                  pos_valid;
    logic [FRAC_BITS-1:0]  pos_quot;
    tag_t                  pos_tag;
    vals_t                 pos_vals;
    logic                  wgt_valid;
    logic signed [W_W-1:0] w0, w1, w2, w3;
    vals_t                 wgt_vals;

    // Global advance: move when the output register is empty or drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Request unpacking
    assign in_vals.left_value       = s_tdata[127:96];
    assign in_vals.left_out_tangent = s_tdata[159:128];
    assign in_vals.right_in_tangent = s_tdata[191:160];
    assign in_vals.right_value      = s_tdata[223:192];

    skf_pos #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pos (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .query_time (s_tdata[31:0]),
        .left_time  (s_tdata[63:32]),
        .right_time (s_tdata[95:64]),
        .in_vals    (in_vals),
        .in_mode    (s_tuser),
        .out_valid  (pos_valid),
        .quot       (pos_quot),
        .out_tag    (pos_tag),
        .out_vals   (pos_vals)
    );

    skf_wgt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_wgt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pos_valid),
        .quot      (pos_quot),
        .in_tag    (pos_tag),
        .in_vals   (pos_vals),
        .out_valid (wgt_valid),
        .w0        (w0),
        .w1        (w1),
        .w2        (w2),
        .w3        (w3),
        .out_vals  (wgt_vals)
    );

    skf_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (wgt_valid),
        .w0        (w0),
        .w1        (w1),
        .w2        (w2),
        .w3        (w3),
        .in_vals   (wgt_vals),
        .out_valid (m_tvalid),
        .out_value (m_tdata)
    );

endmodule

// ----- rtl/skf_checker.sv -----
// Port-level checks for the scalar keyframe interpolator, bound to the top.
// Depends on skf_pkg for the result width.
module skf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [skf_pkg::OUT_DATA_W-1:0] m_tdata
);
    import skf_pkg::*;

    // A stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Input side is ready exactly when the output register can move
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output stall");

    // Reset empties the pipe; the output is clear from the next edge on
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

    // Nothing can reach the output on the first edge after reset
    a_reset_exit: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid && s_tready)
        else $error("pipe not empty when leaving reset");

endmodule

bind scalar_keyframe_interpolator skf_checker u_skf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
